>>> hw/rtl/pba_pkg.sv
// Shared constants, request codes, state encoding and interface structs for the
// page bitmap allocator. No dependencies; every other file of the block imports it.
package pba_pkg;

  localparam int unsigned MAX_PAGES  = 32768;
  localparam int unsigned PAGE_BYTES = 4096;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned BYTES_W    = 28;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TYPE_W     = 2;

  localparam int unsigned IDX_W      = $clog2(MAX_PAGES);
  localparam int unsigned PAGE_W     = IDX_W + 1;
  localparam int unsigned ROW_BITS   = 8;
  localparam int unsigned SEL_W      = $clog2(ROW_BITS);
  localparam int unsigned ROW_AW     = IDX_W - SEL_W;
  localparam int unsigned ROWS       = MAX_PAGES / ROW_BITS;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned SUM_W      = ADDR_W + 1;
  localparam int unsigned SPAN_W     = SUM_W - PAGE_SHIFT;
  localparam int unsigned TOT_W      = ((PAGE_W > COUNT_W) ? PAGE_W : COUNT_W) + 1;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'h8000_0000;
  localparam logic [COUNT_W-1:0] PAGES_RESET = 16'd32768;

  localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RESERVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_TRACKED = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_FOUND,
    S_PREP,
    S_MARK,
    S_RESP
  } pba_state_e;

  typedef struct packed {
    logic                en;
    logic [ROW_AW-1:0]   addr;
    logic [ROW_BITS-1:0] mask;
    logic                set;
  } pba_wr_t;

  typedef struct packed {
    logic              found;
    logic [SEL_W-1:0]  pos;
    logic [PAGE_W-1:0] run;
  } pba_eval_t;

endpackage

>>> hw/rtl/pba_bitmap.sv
// Used/free bitmap memory, rows of eight pages each, with bit-masked writes and a
// registered read port. Clears itself row by row after reset. Depends on pba_pkg.
module pba_bitmap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [pba_pkg::ROW_AW-1:0]     rd_addr_i,
  output logic [pba_pkg::ROW_BITS-1:0]   rd_data_o,
  input  pba_pkg::pba_wr_t               wr_i,
  output logic                           busy_o
);
  import pba_pkg::*;

  logic [ROW_BITS-1:0] mem_q [ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic                clr_q, clr_d;
  logic [ROW_AW-1:0]   clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ROW_AW'(ROWS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_i.en) begin
      for (int j = 0; j < ROW_BITS; j++) begin
        if (wr_i.mask[j]) begin
          mem_q[wr_i.addr][j] <= wr_i.set;
        end
      end
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

>>> hw/rtl/pba_run_eval.sv
// Free-run evaluator for one bitmap row: extends the carried run length across
// eight pages and reports the first page that completes the request. Uses pba_pkg.
module pba_run_eval (
  input  logic [pba_pkg::ROW_BITS-1:0] row_i,
  input  logic [pba_pkg::ROW_BITS-1:0] elig_i,
  input  logic [pba_pkg::PAGE_W-1:0]   carry_i,
  input  logic [pba_pkg::COUNT_W-1:0]  need_i,
  output pba_pkg::pba_eval_t           eval_o
);
  import pba_pkg::*;

  always_comb begin
    logic [SEL_W:0]   len;
    logic             touch;
    logic             free;
    logic [TOT_W-1:0] tot;
    len    = '0;
    touch  = 1'b1;
    eval_o = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      free = elig_i[j] & ~row_i[j];
      if (free) begin
        len = len + 1'b1;
      end else begin
        len   = '0;
        touch = 1'b0;
      end
      tot = TOT_W'(len) + (touch ? TOT_W'(carry_i) : TOT_W'(0));
      if (!free) begin
        tot = '0;
      end
      if (free && (tot >= TOT_W'(need_i)) && !eval_o.found) begin
        eval_o.found = 1'b1;
        eval_o.pos   = SEL_W'(j);
      end
      if (j == ROW_BITS - 1) begin
        eval_o.run = PAGE_W'(tot);
      end
    end
  end

endmodule

>>> hw/rtl/page_bitmap_allocator.sv
// Page bitmap allocator top level: request sequencer around the bitmap memory.
// An allocate passes S_START, S_SCAN row by row, S_FOUND, S_MARK row by row and S_RESP, back
// through S_START when the search restarts from page zero. Free and reserve: S_PREP, then
// S_MARK row by row if a whole page is covered, S_RESP. A zero-page allocate or unknown request
// goes straight to S_RESP. One request is in flight at a time; the next is taken the cycle
// after its result is loaded. Reset clears the bitmap one row per cycle with in_ready_o low. Uses pba_pkg.
module page_bitmap_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pba_pkg::ADDR_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pba_pkg::TYPE_W-1:0]        req_type_i,
  input  logic [pba_pkg::COUNT_W-1:0]       page_count_i,
  input  logic [pba_pkg::ADDR_W-1:0]        range_address_i,
  input  logic [pba_pkg::ADDR_W-1:0]        range_bytes_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              status_o,
  output logic [pba_pkg::ADDR_W-1:0]        block_address_o,
  output logic [pba_pkg::BYTES_W-1:0]       block_bytes_o
);
  import pba_pkg::*;

  pba_state_e          state_q, state_d;
  logic [PAGE_W-1:0]   cursor_q, cursor_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [COUNT_W-1:0]  ptrack_q, ptrack_d;
  logic                pass_q, pass_d;
  logic                out_valid_q, out_valid_d;

  logic [TYPE_W-1:0]   req_q, req_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0]   rel_q, rel_d;
  logic [ADDR_W-1:0]   len_q, len_d;
  logic [PAGE_W-1:0]   limit_q, limit_d;
  logic [PAGE_W-1:0]   scan_from_q, scan_from_d;
  logic [ROW_AW-1:0]   row_q, row_d;
  logic [PAGE_W-1:0]   run_q, run_d;
  logic [IDX_W-1:0]    hit_q, hit_d;
  logic [IDX_W-1:0]    mark_first_q, mark_first_d;
  logic [PAGE_W-1:0]   mark_last_q, mark_last_d;
  logic [ROW_AW-1:0]   mark_row_q, mark_row_d;
  logic                mark_set_q, mark_set_d;
  logic                st_q, st_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  logic                status_q;
  logic [ADDR_W-1:0]   block_address_q;
  logic [BYTES_W-1:0]  block_bytes_q;

  logic                busy;
  logic                rd_en;
  logic [ROW_AW-1:0]   rd_addr;
  logic [ROW_BITS-1:0] rd_data;
  pba_wr_t             wr;
  logic [ROW_BITS-1:0] elig;
  pba_eval_t           eval;
  logic [PAGE_W-1:0]   last_m1;
  logic                resp_load;

  pba_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr),
    .busy_o    (busy)
  );

  pba_run_eval u_eval (
    .row_i   (rd_data),
    .elig_i  (elig),
    .carry_i (run_q),
    .need_i  (count_q),
    .eval_o  (eval)
  );

  assign resp_load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign last_m1   = mark_last_q - 1'b1;

  always_comb begin
    logic [PAGE_W-1:0] lim;
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] row_end;
    logic [SPAN_W-1:0] first_full;
    logic [SPAN_W-1:0] last_full;
    logic [SPAN_W-1:0] last_c;
    state_d      = state_q;
    cursor_d     = cursor_q;
    base_d       = base_q;
    ptrack_d     = ptrack_q;
    pass_d       = pass_q;
    out_valid_d  = out_valid_q;
    req_d        = req_q;
    count_d      = count_q;
    rel_d        = rel_q;
    len_d        = len_q;
    limit_d      = limit_q;
    scan_from_d  = scan_from_q;
    row_d        = row_q;
    run_d        = run_q;
    hit_d        = hit_q;
    mark_first_d = mark_first_q;
    mark_last_d  = mark_last_q;
    mark_row_d   = mark_row_q;
    mark_set_d   = mark_set_q;
    st_d         = st_q;
    addr_d       = addr_q;
    bytes_d      = bytes_q;

    if (32'(ptrack_q) > 32'(MAX_PAGES)) begin
      lim = PAGE_W'(MAX_PAGES);
    end else begin
      lim = PAGE_W'(ptrack_q);
    end
    start      = PAGE_W'(hit_q) + 1'b1 - PAGE_W'(count_q);
    row_end    = {(PAGE_W - SEL_W)'({1'b0, row_q}) + 1'b1, SEL_W'(0)};
    first_full = SPAN_W'((SUM_W'(rel_q) + SUM_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
    last_full  = SPAN_W'((SUM_W'(rel_q) + SUM_W'(len_q)) >> PAGE_SHIFT);
    if (last_full > SPAN_W'(MAX_PAGES)) begin
      last_c = SPAN_W'(MAX_PAGES);
    end else begin
      last_c = last_full;
    end

    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MEM_BASE) begin
        base_d = cfg_data_i;
      end else if (cfg_index_i == CFG_PAGES_TRACKED) begin
        ptrack_d = cfg_data_i[COUNT_W-1:0];
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (resp_load) begin
      out_valid_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d       = req_type_i;
          count_d     = page_count_i;
          rel_d       = range_address_i - base_q;
          len_d       = range_bytes_i;
          limit_d     = lim;
          scan_from_d = cursor_q;
          pass_d      = 1'b0;
          st_d        = 1'b0;
          addr_d      = '0;
          bytes_d     = '0;
          case (req_type_i)
            REQ_ALLOC: begin
              state_d = (page_count_i == '0) ? S_RESP : S_START;
            end
            REQ_FREE, REQ_RESERVE: begin
              state_d = S_PREP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_START: begin
        if (scan_from_q >= limit_q) begin
          if (!pass_q) begin
            pass_d      = 1'b1;
            scan_from_d = '0;
            cursor_d    = '0;
          end else begin
            st_d    = 1'b1;
            state_d = S_RESP;
          end
        end else begin
          row_d   = scan_from_q[IDX_W-1:SEL_W];
          run_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (eval.found) begin
          hit_d   = {row_q, eval.pos};
          state_d = S_FOUND;
        end else begin
          run_d = eval.run;
          if (row_end >= limit_q) begin
            if (!pass_q) begin
              pass_d      = 1'b1;
              scan_from_d = '0;
              cursor_d    = '0;
              state_d     = S_START;
            end else begin
              st_d    = 1'b1;
              state_d = S_RESP;
            end
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      S_FOUND: begin
        mark_first_d = start[IDX_W-1:0];
        mark_last_d  = PAGE_W'(hit_q) + 1'b1;
        cursor_d     = PAGE_W'(hit_q) + 1'b1;
        mark_set_d   = 1'b1;
        mark_row_d   = start[IDX_W-1:SEL_W];
        addr_d       = base_q + (ADDR_W'(start) << PAGE_SHIFT);
        bytes_d      = BYTES_W'(count_q) << PAGE_SHIFT;
        state_d      = S_MARK;
      end
      S_PREP: begin
        if (first_full >= last_c) begin
          state_d = S_RESP;
        end else begin
          mark_first_d = first_full[IDX_W-1:0];
          mark_last_d  = PAGE_W'(last_c);
          mark_set_d   = (req_q == REQ_RESERVE);
          mark_row_d   = first_full[IDX_W-1:SEL_W];
          state_d      = S_MARK;
        end
      end
      S_MARK: begin
        if (mark_row_q == last_m1[IDX_W-1:SEL_W]) begin
          state_d = S_RESP;
        end else begin
          mark_row_d = mark_row_q + 1'b1;
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    logic [SEL_W-1:0]  lo;
    logic [SEL_W-1:0]  hi;
    logic [PAGE_W-1:0] page;
    in_ready_o  = (state_q == S_IDLE) && !busy;
    cfg_ready_o = 1'b1;
    rd_en       = 1'b0;
    rd_addr     = row_q + 1'b1;
    if (state_q == S_START) begin
      rd_en   = 1'b1;
      rd_addr = scan_from_q[IDX_W-1:SEL_W];
    end else if (state_q == S_SCAN) begin
      rd_en = 1'b1;
    end

    for (int j = 0; j < ROW_BITS; j++) begin
      page    = PAGE_W'({row_q, SEL_W'(j)});
      elig[j] = (page >= scan_from_q) && (page < limit_q);
    end

    lo = (mark_row_q == mark_first_q[IDX_W-1:SEL_W]) ? mark_first_q[SEL_W-1:0] : '0;
    hi = (mark_row_q == last_m1[IDX_W-1:SEL_W]) ? last_m1[SEL_W-1:0] : '1;
    wr.en   = (state_q == S_MARK);
    wr.addr = mark_row_q;
    wr.set  = mark_set_q;
    for (int j = 0; j < ROW_BITS; j++) begin
      wr.mask[j] = (SEL_W'(j) >= lo) && (SEL_W'(j) <= hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      base_q      <= BASE_RESET;
      ptrack_q    <= PAGES_RESET;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      base_q      <= base_d;
      ptrack_q    <= ptrack_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    count_q      <= count_d;
    rel_q        <= rel_d;
    len_q        <= len_d;
    limit_q      <= limit_d;
    scan_from_q  <= scan_from_d;
    row_q        <= row_d;
    run_q        <= run_d;
    hit_q        <= hit_d;
    mark_first_q <= mark_first_d;
    mark_last_q  <= mark_last_d;
    mark_row_q   <= mark_row_d;
    mark_set_q   <= mark_set_d;
    st_q         <= st_d;
    addr_q       <= addr_d;
    bytes_q      <= bytes_d;
    if (resp_load) begin
      status_q        <= st_q;
      block_address_q <= addr_q;
      block_bytes_q   <= bytes_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign block_address_o = block_address_q;
  assign block_bytes_o   = block_bytes_q;

endmodule

>>> tb/pba_alloc_monitor.sv
`timescale 1ns / 1ps
// Transfer monitor and predictor for the page bitmap allocator: keeps its own page bitmap,
// next-fit cursor and register copies, and checks each result transfer against them in order.
// Depends on pba_pkg for widths, request codes and register indexes.
module pba_alloc_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pba_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [pba_pkg::TYPE_W-1:0]    req_type_i,
  input  logic [pba_pkg::COUNT_W-1:0]   page_count_i,
  input  logic [pba_pkg::ADDR_W-1:0]    range_address_i,
  input  logic [pba_pkg::ADDR_W-1:0]    range_bytes_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          status_i,
  input  logic [pba_pkg::ADDR_W-1:0]    block_address_i,
  input  logic [pba_pkg::BYTES_W-1:0]   block_bytes_i,
  output int                            fail_count_o = 0,
  output int                            outstanding_o = 0
);
  import pba_pkg::*;

  typedef struct packed {
    logic               status;
    logic [ADDR_W-1:0]  address;
    logic [BYTES_W-1:0] nbytes;
  } grant_t;

  bit                 page_used [MAX_PAGES];
  int unsigned        next_fit_cursor = 0;
  logic [ADDR_W-1:0]  base_reg = BASE_RESET;
  logic [COUNT_W-1:0] pages_reg = PAGES_RESET;
  grant_t             awaited_grants [$];
  int                 mismatches = 0;

  function automatic bit find_free_run(input int unsigned origin, input int unsigned lim,
                                       input int unsigned want_len,
                                       output int unsigned run_start);
    int unsigned run_len;
    int unsigned run_first;
    run_len = 0;
    run_first = 0;
    run_start = 0;
    for (int unsigned i = origin; i < lim; i++) begin
      if (page_used[i]) begin
        run_len = 0;
      end else begin
        if (run_len == 0) run_first = i;
        run_len++;
        if (run_len == want_len) begin
          run_start = run_first;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void mark_pages(input longint unsigned first_page,
                                     input longint unsigned end_page, input bit used);
    longint unsigned stop;
    stop = (end_page > MAX_PAGES) ? MAX_PAGES : end_page;
    for (longint unsigned p = first_page; p < stop; p++) page_used[p] = used;
  endfunction

  function automatic void mark_byte_range(input logic [ADDR_W-1:0] addr,
                                          input logic [ADDR_W-1:0] nbytes, input bit used);
    logic [ADDR_W-1:0] offset;
    longint unsigned   rel;
    offset = addr - base_reg;
    rel = offset;
    // Bounds are rounded inward, so a partial page at either end stays as it was.
    mark_pages((rel + PAGE_BYTES - 1) / PAGE_BYTES, (rel + nbytes) / PAGE_BYTES, used);
  endfunction

  function automatic grant_t apply_request(input logic [TYPE_W-1:0] kind,
                                           input logic [COUNT_W-1:0] count,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [ADDR_W-1:0] nbytes);
    grant_t      g;
    int unsigned lim;
    int unsigned run_start;
    bit          found;
    g = '0;
    case (kind)
      REQ_ALLOC: begin
        lim = (pages_reg > MAX_PAGES) ? MAX_PAGES : pages_reg;
        if (count != 0) begin
          found = find_free_run(next_fit_cursor, lim, count, run_start);
          if (!found) begin
            next_fit_cursor = 0;
            found = find_free_run(0, lim, count, run_start);
          end
          if (!found) begin
            g.status = 1'b1;
          end else begin
            mark_pages(run_start, run_start + count, 1'b1);
            next_fit_cursor = run_start + count;
            g.address = base_reg + run_start * PAGE_BYTES;
            g.nbytes = BYTES_W'(32'(count) * PAGE_BYTES);
          end
        end
      end
      REQ_FREE:    mark_byte_range(addr, nbytes, 1'b0);
      REQ_RESERVE: mark_byte_range(addr, nbytes, 1'b1);
      default: ;
    endcase
    return g;
  endfunction

  function automatic void note_mismatch(input string what, input grant_t want,
                                        input grant_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: status %0d/%0d address %h/%h bytes %h/%h (expected/actual)",
               $time, what, want.status, seen.status, want.address, seen.address,
               want.nbytes, seen.nbytes);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    grant_t seen;
    grant_t due;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MEM_BASE:      base_reg = cfg_data_i;
          CFG_PAGES_TRACKED: pages_reg = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      // Results are matched before new requests are queued, so a result can never pair
      // with a request accepted on the same edge.
      if (out_valid_i && out_ready_i) begin
        seen = '{status_i, block_address_i, block_bytes_i};
        if (awaited_grants.size() == 0) begin
          note_mismatch("result transfer with nothing outstanding", '0, seen);
        end else begin
          due = awaited_grants.pop_front();
          if (due.status != seen.status || due.address != seen.address ||
              due.nbytes != seen.nbytes) begin
            note_mismatch("result mismatch", due, seen);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_grants.push_back(apply_request(req_type_i, page_count_i, range_address_i,
                                               range_bytes_i));
      end
    end
    fail_count_o <= mismatches;
    outstanding_o <= awaited_grants.size();
  end

endmodule

>>> tb/tb_page_bitmap_allocator.sv
`timescale 1ns / 1ps
// Top of the page bitmap allocator testbench: clock, reset, directed and random requests,
// register writes between phases, result back-pressure, watchdog and verdict.
// Depends on pba_pkg, page_bitmap_allocator and pba_alloc_monitor.
module tb_page_bitmap_allocator;
  import pba_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 100000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [TYPE_W-1:0]    req_type_i = '0;
  logic [COUNT_W-1:0]   page_count_i = '0;
  logic [ADDR_W-1:0]    range_address_i = '0;
  logic [ADDR_W-1:0]    range_bytes_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 status_o;
  logic [ADDR_W-1:0]    block_address_o;
  logic [BYTES_W-1:0]   block_bytes_o;

  int                   fail_count;
  int                   outstanding;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   quiet_cycles = 0;
  logic [ADDR_W-1:0]    cur_base = BASE_RESET;
  logic [COUNT_W-1:0]   cur_pages = PAGES_RESET;

  page_bitmap_allocator DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .req_type_i, .page_count_i, .range_address_i, .range_bytes_i,
    .out_valid_o, .out_ready_i, .status_o, .block_address_o, .block_bytes_o
  );

  pba_alloc_monitor u_alloc_monitor (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .page_count_i, .range_address_i,
    .range_bytes_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .block_address_i(block_address_o), .block_bytes_i(block_bytes_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic set_pacing(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic configure(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] pages);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MEM_BASE;
    cfg_data_i <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_PAGES_TRACKED;
    cfg_data_i <= {16'($urandom()), pages};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_base = base;
    cur_pages = pages;
  endtask

  task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [COUNT_W-1:0] count,
                          input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] nbytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    page_count_i <= count;
    range_address_i <= addr;
    range_bytes_i <= nbytes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic random_request();
    int unsigned        lim;
    int unsigned        pick;
    logic [TYPE_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  nbytes;
    lim = (cur_pages == 0) ? 1 : ((cur_pages > MAX_PAGES) ? MAX_PAGES : cur_pages);
    pick = $urandom_range(99);
    count = 16'($urandom());
    addr = $urandom();
    nbytes = $urandom();
    if (pick < 45) begin
      kind = REQ_ALLOC;
      pick = $urandom_range(99);
      if (pick < 88) count = 16'($urandom_range(1, (lim < 96) ? (lim + 1) / 2 : 48));
      else if (pick < 91) count = '0;
      else if (pick < 94) count = 16'($urandom_range(1, lim));
    end else begin
      kind = (pick < 73) ? REQ_FREE : (pick < 95) ? REQ_RESERVE : REQ_UNUSED;
      if ($urandom_range(99) < 85) begin
        addr = cur_base + $urandom_range(0, lim) * PAGE_BYTES;
        if ($urandom_range(1)) addr += $urandom_range(0, PAGE_BYTES - 1);
      end
      pick = $urandom_range(99);
      if (pick < 90) nbytes = $urandom_range(0, ((lim < 64) ? lim : 64) * PAGE_BYTES);
      else if (pick < 95) nbytes = $urandom_range(0, PAGE_BYTES);
    end
    send_req(kind, count, addr, nbytes);
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0]  base;
    logic [COUNT_W-1:0] pages;
    int                 items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small tracked window: fill it, run out, punch holes and refill them.
    set_pacing(0);
    configure(BASE_RESET, 16'd64);
    send_req(REQ_ALLOC, 16'd1, '0, '0);
    send_req(REQ_ALLOC, 16'd0, '1, '1);
    send_req(REQ_ALLOC, 16'd64, '0, '0);
    send_req(REQ_ALLOC, 16'd63, '0, '0);
    send_req(REQ_ALLOC, 16'd1, '0, '0);
    send_req(REQ_FREE, '0, BASE_RESET + 10 * PAGE_BYTES, 5 * PAGE_BYTES);
    send_req(REQ_FREE, '0, BASE_RESET + 20 * PAGE_BYTES + 1, 3 * PAGE_BYTES);
    send_req(REQ_ALLOC, 16'd5, '0, '0);
    send_req(REQ_ALLOC, 16'd2, '0, '0);
    send_req(REQ_RESERVE, '0, BASE_RESET - PAGE_BYTES, 3 * PAGE_BYTES);
    send_req(REQ_FREE, '0, BASE_RESET + PAGE_BYTES + 1, 32'd100);
    send_req(REQ_RESERVE, '0, BASE_RESET + 30 * PAGE_BYTES, '0);
    send_req(REQ_UNUSED, '1, '1, '1);
    send_req(REQ_RESERVE, '0, '1, '1);
    send_req(REQ_FREE, '0, '0, '0);
    send_req(REQ_FREE, '0, BASE_RESET, '1);
    send_req(REQ_ALLOC, 16'hFFFF, '0, '0);
    send_req(REQ_ALLOC, 16'd40, '0, '0);
    settle();

    // The cursor now lies past the shrunken window, and the base makes addresses wrap.
    set_pacing(1);
    configure(32'hFFFF_F000, 16'd16);
    send_req(REQ_FREE, '0, 32'hFFFF_F000, '1);
    send_req(REQ_ALLOC, 16'd3, '0, '0);
    send_req(REQ_ALLOC, 16'd3, '0, '0);
    settle();

    set_pacing(2);
    configure('0, 16'd32768);
    send_req(REQ_FREE, '0, '0, '1);
    send_req(REQ_ALLOC, 16'd32768, '0, '0);
    send_req(REQ_ALLOC, 16'd1, '0, '0);
    settle();

    set_pacing(3);
    configure(32'h1234_5000, 16'd0);
    send_req(REQ_ALLOC, 16'd1, '0, '0);
    settle();
    configure(32'h1234_5000, 16'hFFFF);
    send_req(REQ_FREE, '0, 32'h1234_5000, '1);
    send_req(REQ_ALLOC, 16'd2, '0, '0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      items = 130;
      base = $urandom();
      case (ph)
        0:  begin base = BASE_RESET;   pages = 16'd64;                end
        1:  begin base = '0;           pages = 16'd1;    items = 60;  end
        2:  pages = 16'd256;
        3:  begin base = '1;           pages = 16'd37;                end
        4:  pages = 16'd512;
        5:  begin base = 32'hFFFF_0000; pages = 16'd8;   items = 100; end
        6:  pages = 16'd128;
        7:  begin                      pages = 16'd32768; items = 60; end
        8:  pages = 16'd1000;
        9:  begin base = 32'h0000_1000; pages = 16'd200;              end
        10: pages = 16'd96;
        default: begin                 pages = 16'd2048; items = 110; end
      endcase
      set_pacing(ph);
      configure(base, pages);
      repeat (items) random_request();
      settle();
    end

    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_bitmap.sv
hw/rtl/pba_run_eval.sv
hw/rtl/page_bitmap_allocator.sv
tb/pba_alloc_monitor.sv
tb/tb_page_bitmap_allocator.sv
